>>> sv/rppd_pkg.sv
// ---------------------------------------------------------------------------
// rppd_pkg: shared types and constants of the remote panel decoder
// Request and response payloads, frame event codes, register indexes and the
// hex and axis scaling helpers used by the frame checker.
// ---------------------------------------------------------------------------
package rppd_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              send_poll;
      logic              panel_alive;
      logic [1:0]        frame_event;
      logic signed [7:0] left_x;
      logic signed [7:0] left_y;
      logic signed [7:0] right_x;
      logic signed [7:0] right_y;
      logic [12:0]       buttons;
   } rsp_type;

   typedef enum logic [1:0] {
      EV_NONE      = 2'd0,
      EV_ACTIVE    = 2'd1,
      EV_RADIO_OFF = 2'd2,
      EV_REJECT    = 2'd3
   } frame_event_type;

   // request kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic CSR_TICK_PERIOD = 1'b0;
   localparam logic CSR_TIMEOUT     = 1'b1;

   localparam logic [7:0]  TICK_PERIOD_RST = 8'd10;
   localparam logic [15:0] TIMEOUT_RST     = 16'd400;

   localparam logic [5:0] FRAME_LEN  = 6'd36;
   // only bytes 0..20 are looked at before the closing byte
   localparam int         FRAME_KEEP = 21;
   localparam int         KEEP_W     = 5;

   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_3      = 8'h33;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_Z      = 8'h7A;
   localparam logic [7:0] MARK_ZERO = 8'h30;
   localparam logic [7:0] MODE_ON   = 8'h38;
   localparam logic [7:0] MODE_OFF  = 8'h34;
   localparam logic [7:0] AXIS_BIAS = 8'd96;

   typedef struct packed {
      frame_event_type  frame_event;
      logic [3:0][7:0]  axes;
      logic [12:0]      buttons;
   } frm_res_type;

   typedef struct packed {
      logic poll;
      logic retry;
   } tmr_res_type;

   // {valid, digit}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
      logic [4:0] h;
      logic [4:0] l;
      logic [7:0] r;
      h = hex_val(hi);
      l = hex_val(lo);
      if (!h[4]) begin
         r = 8'd0;
      end else if (!l[4]) begin
         r = {4'd0, h[3:0]};
      end else begin
         r = {h[3:0], l[3:0]};
      end
      return r;
   endfunction

   // 3*a - 96, modulo 256
   function automatic logic [7:0] scale_pos(input logic [5:0] a);
      logic [7:0] t;
      t = {2'b00, a} + {1'b0, a, 1'b0};
      return t - AXIS_BIAS;
   endfunction

   function automatic logic [7:0] scale_neg(input logic [5:0] a);
      logic [7:0] t;
      t = {2'b00, a} + {1'b0, a, 1'b0};
      return AXIS_BIAS - t;
   endfunction

endpackage

>>> sv/remote_panel_poll_and_frame_decoder_unit.sv
// ---------------------------------------------------------------------------
// remote_panel_poll_and_frame_decoder_unit: remote panel poller and decoder
// Takes received bytes and millisecond ticks, requests polls and decodes the
// panel's 36-byte replies into joystick axes, buttons and an alive flag.
// ---------------------------------------------------------------------------
// Every request gives exactly one response. A request is registered, decoded
// by combinational logic (byte capture and frame check, or the elapsed-time
// update) and its response lands in an output register; a new request is
// taken every cycle and the pipeline only stalls while a response waits
// with rsp_ready low. The frame check runs on the cycle of the closing byte
// and reads only bytes 0..20 plus the closing byte itself.
module remote_panel_poll_and_frame_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rppd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rppd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   rppd_pkg::req_type     in_ff;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   rppd_pkg::rsp_type     rsp_ff;
   rppd_pkg::rsp_type     rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [7:0]            tick_period_ff;
   logic [15:0]           timeout_ff;
   logic                  alive_ff;
   logic                  alive_in;
   logic [3:0][7:0]       axes_ff;
   logic [3:0][7:0]       axes_in;
   logic [12:0]           buttons_ff;
   logic [12:0]           buttons_in;
   logic                  advance;
   logic                  step;
   logic                  frame_ok;
   rppd_pkg::frm_res_type frm_res;
   rppd_pkg::tmr_res_type tmr_res;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= rppd_pkg::TICK_PERIOD_RST;
         timeout_ff     <= rppd_pkg::TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rppd_pkg::CSR_TICK_PERIOD: tick_period_ff <= csr_wdata[7:0];
            rppd_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   rppd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .is_byte     (in_ff.cmd == rppd_pkg::CMD_BYTE),
      .rx_byte     (in_ff.rx_byte),
      .clear_count (tmr_res.poll),
      .frm_res     (frm_res)
   );

   assign frame_ok = (frm_res.frame_event == rppd_pkg::EV_ACTIVE) ||
                     (frm_res.frame_event == rppd_pkg::EV_RADIO_OFF);

   rppd_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .is_tick     (in_ff.cmd == rppd_pkg::CMD_TICK),
      .frame_ok    (frame_ok),
      .tick_period (tick_period_ff),
      .timeout     (timeout_ff),
      .tmr_res     (tmr_res)
   );

   // decoded panel data
   always_comb begin
      alive_in   = alive_ff;
      axes_in    = axes_ff;
      buttons_in = buttons_ff;
      if (frm_res.frame_event == rppd_pkg::EV_ACTIVE) begin
         alive_in   = 1'b1;
         axes_in    = frm_res.axes;
         buttons_in = frm_res.buttons;
      end else if ((frm_res.frame_event == rppd_pkg::EV_RADIO_OFF) || tmr_res.retry) begin
         alive_in   = 1'b0;
         axes_in    = '0;
         buttons_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff   <= 1'b0;
         axes_ff    <= '0;
         buttons_ff <= '0;
      end else begin
         alive_ff   <= alive_in;
         axes_ff    <= axes_in;
         buttons_ff <= buttons_in;
      end
   end

   // output register
   always_comb begin
      rsp_in.send_poll   = tmr_res.poll;
      rsp_in.panel_alive = alive_in;
      rsp_in.frame_event = frm_res.frame_event;
      rsp_in.left_x      = axes_in[0];
      rsp_in.left_y      = axes_in[1];
      rsp_in.right_x     = axes_in[2];
      rsp_in.right_y     = axes_in[3];
      rsp_in.buttons     = buttons_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted active frame always leaves the panel alive
   a_active_alive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.frame_event == rppd_pkg::EV_ACTIVE)) |-> rsp_ff.panel_alive)
      else $error("active frame without panel alive");

   // radio-off frame clears the alive flag, buttons and axes (left_x is checked)
   a_off_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.frame_event == rppd_pkg::EV_RADIO_OFF)) |->
      (!rsp_ff.panel_alive && (rsp_ff.buttons == 13'd0) && (rsp_ff.left_x == 8'sd0)))
      else $error("radio-off frame left data behind");

   // a poll comes only from a tick, which never reports a frame
   a_poll_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.send_poll) |-> (rsp_ff.frame_event == rppd_pkg::EV_NONE))
      else $error("poll and frame event in one response");

endmodule

>>> sv/rppd_frame.sv
// ---------------------------------------------------------------------------
// rppd_frame: receive byte counter, frame capture and frame check
// Counts received bytes, keeps the bytes that the check needs and decodes
// the frame when its closing byte arrives.
// ---------------------------------------------------------------------------
module rppd_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  is_byte,
   input  logic [7:0]            rx_byte,
   input  logic                  clear_count,
   output rppd_pkg::frm_res_type frm_res
);

   logic [5:0]                byte_count_ff;
   logic [5:0]                byte_count_in;
   logic [7:0]                frame_ff [rppd_pkg::FRAME_KEEP];
   logic                      take;
   logic                      last_byte;
   logic                      hdr_ok;
   rppd_pkg::frame_event_type frame_event;
   logic [7:0]                lx_pair;
   logic [7:0]                ly_pair;
   logic [7:0]                rx_pair;
   logic [7:0]                ry_pair;

   assign take      = step && is_byte && (byte_count_ff < rppd_pkg::FRAME_LEN);
   assign last_byte = take && (byte_count_ff == rppd_pkg::FRAME_LEN - 6'd1);

   always_comb begin
      byte_count_in = byte_count_ff;
      if (clear_count) begin
         byte_count_in = '0;
      end else if (take) begin
         byte_count_in = byte_count_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && (byte_count_ff < 6'(rppd_pkg::FRAME_KEEP))) begin
         frame_ff[byte_count_ff[rppd_pkg::KEEP_W-1:0]] <= rx_byte;
      end
   end

   // closing byte is checked straight from the request
   assign hdr_ok = (frame_ff[0] == rppd_pkg::CH_X) && (frame_ff[1] == rppd_pkg::CH_3) &&
                   (frame_ff[2] == rppd_pkg::CH_1) &&
                   (frame_ff[14] == rppd_pkg::MARK_ZERO) && (rx_byte == rppd_pkg::CH_Z);

   always_comb begin
      frame_event = rppd_pkg::EV_NONE;
      if (last_byte) begin
         if (!hdr_ok) begin
            frame_event = rppd_pkg::EV_REJECT;
         end else if (frame_ff[13] == rppd_pkg::MODE_ON) begin
            frame_event = rppd_pkg::EV_ACTIVE;
         end else if (frame_ff[13] == rppd_pkg::MODE_OFF) begin
            frame_event = rppd_pkg::EV_RADIO_OFF;
         end else begin
            frame_event = rppd_pkg::EV_REJECT;
         end
      end
   end

   assign frm_res.frame_event = frame_event;

   assign lx_pair = rppd_pkg::hex_pair(frame_ff[12], frame_ff[9]);
   assign ly_pair = rppd_pkg::hex_pair(frame_ff[11], frame_ff[12]);
   assign rx_pair = rppd_pkg::hex_pair(frame_ff[7], frame_ff[8]);
   assign ry_pair = rppd_pkg::hex_pair(frame_ff[10], frame_ff[7]);

   // x axes keep the low six bits, y axes drop the low two
   assign frm_res.axes[0] = rppd_pkg::scale_pos(lx_pair[5:0]);
   assign frm_res.axes[1] = rppd_pkg::scale_pos(ly_pair[7:2]);
   assign frm_res.axes[2] = rppd_pkg::scale_pos(rx_pair[5:0]);
   assign frm_res.axes[3] = rppd_pkg::scale_neg(ry_pair[7:2]);

   assign frm_res.buttons = {frame_ff[17][0], frame_ff[17][1], frame_ff[17][2],
                             frame_ff[20][3], frame_ff[20][2], frame_ff[17][3],
                             frame_ff[20][0], frame_ff[20][1], frame_ff[19][0],
                             frame_ff[18][2], frame_ff[18][3], frame_ff[18][0],
                             frame_ff[15][2]};

endmodule

>>> sv/rppd_timer.sv
// ---------------------------------------------------------------------------
// rppd_timer: elapsed time counter and poll scheduling
// Advances the saturating millisecond counter on ticks and decides between
// a normal poll, a timeout retry and no poll.
// ---------------------------------------------------------------------------
module rppd_timer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  is_tick,
   input  logic                  frame_ok,
   input  logic [7:0]            tick_period,
   input  logic [15:0]           timeout,
   output rppd_pkg::tmr_res_type tmr_res
);

   logic [15:0] elapsed_ff;
   logic [15:0] elapsed_in;
   logic        ready_ff;
   logic        ready_in;
   logic [16:0] sum;
   logic [15:0] sat;

   assign sum = {1'b0, elapsed_ff} + {9'd0, tick_period};
   assign sat = sum[16] ? 16'hFFFF : sum[15:0];

   always_comb begin
      elapsed_in    = elapsed_ff;
      ready_in      = ready_ff;
      tmr_res.poll  = 1'b0;
      tmr_res.retry = 1'b0;
      if (step && is_tick) begin
         elapsed_in = sat;
         if (ready_ff) begin
            ready_in     = 1'b0;
            tmr_res.poll = 1'b1;
         end else if (sat >= timeout) begin
            elapsed_in    = '0;
            tmr_res.poll  = 1'b1;
            tmr_res.retry = 1'b1;
         end
      end else if (frame_ok) begin
         elapsed_in = '0;
         ready_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         ready_ff   <= 1'b1;
      end else begin
         elapsed_ff <= elapsed_in;
         ready_ff   <= ready_in;
      end
   end

endmodule
